// File: sv/tnmve_pkg.sv
// Shared types and constants of the tracker note to MIDI voice engine.
// Used by the top level and the RAM sizing; depends on nothing.
`default_nettype none

package tnmve_pkg;

  // Sizing
  localparam int TRACKER_CHANNELS = 64;
  localparam int INSTRUMENT_COUNT = 256;
  localparam int TC_AW = (TRACKER_CHANNELS > 1) ? $clog2(TRACKER_CHANNELS) : 1;
  localparam int MAP_AW = (INSTRUMENT_COUNT > 1) ? $clog2(INSTRUMENT_COUNT) : 1;

  // MIDI constants
  localparam int MIDI_CHANNELS = 16;
  localparam int NOTE_MAX = 127;
  localparam int PROG_LIMIT = 128;
  localparam int VEL_SCALE = 127;
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON = 4'h9;
  localparam logic [3:0] ST_PROGRAM = 4'hC;
  localparam logic [1:0] LEN_NOTE = 2'd3;
  localparam logic [1:0] LEN_PROGRAM = 2'd2;

  // Configuration register indexes
  localparam logic CFG_USE_MAP = 1'b0;
  localparam logic CFG_NOTE_OFFSET = 1'b1;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_NOTE = 2'd0,
    KIND_STOP = 2'd1,
    KIND_RESET_PROG = 2'd2,
    KIND_LOAD_MAP = 2'd3
  } kind_t;

  // Map entry: program above channel
  typedef struct packed {
    logic [7:0] prog_num;
    logic [4:0] channel;
  } map_entry_t;

  // Voice entry: MIDI channel above note
  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] note;
  } voice_entry_t;

endpackage

`default_nettype wire

// File: sv/tnmve_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the voice table and the instrument map.
`default_nettype none

module tnmve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, and read one entry into the registered rdata
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/tracker_note_to_midi_voice_engine_top.sv
// Top level of the tracker note to MIDI voice engine.
// Depends on tnmve_pkg and instantiates tnmve_ram for voice table and map.
`default_nettype none

// Turns tracker note events into three- and two-byte MIDI messages. A map load
// or a program-cache reset is done in the idle state. A note or stop item is
// decided in a lookup state, after the registered read of the voice table and
// instrument map memories, then a send state puts each message through the
// single output register: up to three messages for a note that changes program,
// stops the old voice and starts a new one. Output stalls hold the send state.
// The voice table keeps its valid bits in flops, so no clearing pass follows
// reset. The instrument map must be loaded before it is used with use_map set.
module tracker_note_to_midi_voice_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [5:0] track_chan, [13:6] note, [22:14] instrument, [30:23] volume,
  // [38:31] map_index, [43:39] map_channel, [51:44] map_program, [55:52] zero
  input  wire logic [55:0] in_tdata,
  // [1:0] kind
  input  wire logic [1:0]  in_tuser,
  // Result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] status_byte, [14:8] data_one, [21:15] data_two, [23:22] byte_count
  output logic [23:0]      out_tdata,
  // last_of_run
  output logic             out_tlast,
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SEND
  } state_t;

  // Input field unpack
  logic [5:0] in_tc;
  logic [7:0] in_note;
  logic [8:0] in_instr;
  logic [7:0] in_volume;
  logic [7:0] in_map_index;
  logic [4:0] in_map_channel;
  logic [7:0] in_map_program;

  assign in_tc          = in_tdata[5:0];
  assign in_note        = in_tdata[13:6];
  assign in_instr       = in_tdata[22:14];
  assign in_volume      = in_tdata[30:23];
  assign in_map_index   = in_tdata[38:31];
  assign in_map_channel = in_tdata[43:39];
  assign in_map_program = in_tdata[51:44];

  // Registers
  state_t                                    state_r, state_nxt;
  logic                                      use_map_r;
  logic [7:0]                                note_offset_r;
  tnmve_pkg::kind_t                          kind_r;
  logic [5:0]                                tc_r;
  logic [8:0]                                idx_r;
  logic [6:0]                                mn_r;
  logic [6:0]                                vel_r;
  logic [3:0]                                ch_r, ch_nxt;
  logic [6:0]                                prog_r, prog_nxt;
  tnmve_pkg::voice_entry_t                   off_r, off_nxt;
  logic [2:0]                                pend_r, pend_nxt;
  logic [tnmve_pkg::TRACKER_CHANNELS-1:0]    voice_vld_r, voice_vld_nxt;
  logic [tnmve_pkg::MIDI_CHANNELS-1:0]       prog_vld_r, prog_vld_nxt;
  logic [6:0]                                prog_cache_r [tnmve_pkg::MIDI_CHANNELS];
  logic                                      out_tvalid_r, out_tvalid_nxt;
  logic [23:0]                               out_tdata_r, out_tdata_nxt;
  logic                                      out_tlast_r, out_tlast_nxt;

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Memories
  logic                            map_we;
  tnmve_pkg::map_entry_t           map_wdata, map_rdata;
  logic [tnmve_pkg::MAP_AW-1:0]    map_raddr;
  logic                            voice_we;
  tnmve_pkg::voice_entry_t         voice_wdata, voice_rdata;
  logic [8:0]                      in_idx;

  assign in_idx    = (in_instr != 9'd0) ? (in_instr - 9'd1) : 9'd0;
  assign map_raddr = tnmve_pkg::MAP_AW'(in_idx);
  assign map_we    = in_acc && (tnmve_pkg::kind_t'(in_tuser) == tnmve_pkg::KIND_LOAD_MAP)
                     && (32'(in_map_index) < tnmve_pkg::INSTRUMENT_COUNT);
  assign map_wdata = '{prog_num: in_map_program, channel: in_map_channel};

  tnmve_ram #(
    .WIDTH ($bits(tnmve_pkg::map_entry_t)),
    .DEPTH (tnmve_pkg::INSTRUMENT_COUNT)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (tnmve_pkg::MAP_AW'(in_map_index)),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  tnmve_ram #(
    .WIDTH ($bits(tnmve_pkg::voice_entry_t)),
    .DEPTH (tnmve_pkg::TRACKER_CHANNELS)
  ) u_voice_ram (
    .clk   (clk),
    .we    (voice_we),
    .waddr (tnmve_pkg::TC_AW'(tc_r)),
    .wdata (voice_wdata),
    .raddr (tnmve_pkg::TC_AW'(in_tc)),
    .rdata (voice_rdata)
  );

  // Note: clamp, add signed offset, clamp again
  logic [6:0]        note_cl;
  logic signed [9:0] note_sum;
  logic [6:0]        mn_in;

  assign note_cl  = (in_note > 8'(tnmve_pkg::NOTE_MAX)) ? 7'(tnmve_pkg::NOTE_MAX)
                                                        : in_note[6:0];
  assign note_sum = $signed({3'b000, note_cl}) + 10'(signed'(note_offset_r));
  always_comb begin
    if (note_sum < 10'sd0) begin
      mn_in = 7'd0;
    end else if (note_sum > 10'(tnmve_pkg::NOTE_MAX)) begin
      mn_in = 7'(tnmve_pkg::NOTE_MAX);
    end else begin
      mn_in = note_sum[6:0];
    end
  end

  // Velocity: volume*127/64, saturated
  logic [14:0] vel_prod;
  logic [8:0]  vel_quo;
  logic [6:0]  vel_in;

  assign vel_prod = 15'(in_volume) * 15'(tnmve_pkg::VEL_SCALE);
  assign vel_quo  = vel_prod[14:6];
  assign vel_in   = (vel_quo > 9'(tnmve_pkg::NOTE_MAX)) ? 7'(tnmve_pkg::NOTE_MAX)
                                                        : vel_quo[6:0];

  // Lookup decisions
  logic                         is_note, is_stop, tc_ok, inst_ok, note_en;
  logic                         voice_on, need_prog, need_off, need_on;
  logic [3:0]                   ch_sel;
  logic [tnmve_pkg::TC_AW-1:0]  tc_idx;

  assign tc_idx   = tnmve_pkg::TC_AW'(tc_r);
  assign is_note  = (kind_r == tnmve_pkg::KIND_NOTE);
  assign is_stop  = (kind_r == tnmve_pkg::KIND_STOP);
  assign tc_ok    = 32'(tc_r) < tnmve_pkg::TRACKER_CHANNELS;
  assign inst_ok  = 32'(idx_r) < tnmve_pkg::INSTRUMENT_COUNT;
  assign note_en  = is_note && tc_ok && (!use_map_r || (inst_ok &&
                    (32'(map_rdata.channel) < tnmve_pkg::MIDI_CHANNELS)));
  assign ch_sel   = use_map_r ? map_rdata.channel[3:0] : idx_r[3:0];
  assign voice_on = tc_ok && voice_vld_r[tc_idx];
  assign need_prog = note_en && use_map_r
                     && (32'(map_rdata.prog_num) < tnmve_pkg::PROG_LIMIT)
                     && !(prog_vld_r[ch_sel]
                          && (prog_cache_r[ch_sel] == map_rdata.prog_num[6:0]));
  assign need_off = ((note_en || (is_stop && tc_ok)) && voice_on);
  assign need_on  = note_en && (vel_r != 7'd0);

  assign voice_we    = (state_r == S_LOOKUP) && need_on;
  assign voice_wdata = '{channel: ch_sel, note: mn_r};

  // Message picked for the output register
  logic        out_free;
  logic [23:0] msg;
  logic [2:0]  pend_after;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    msg        = '0;
    pend_after = pend_r;
    if (pend_r[0]) begin
      msg        = {tnmve_pkg::LEN_PROGRAM, 7'd0, prog_r, tnmve_pkg::ST_PROGRAM, ch_r};
      pend_after = pend_r & 3'b110;
    end else if (pend_r[1]) begin
      msg        = {tnmve_pkg::LEN_NOTE, 7'd0, off_r.note, tnmve_pkg::ST_NOTE_OFF,
                    off_r.channel};
      pend_after = pend_r & 3'b100;
    end else begin
      msg        = {tnmve_pkg::LEN_NOTE, vel_r, mn_r, tnmve_pkg::ST_NOTE_ON, ch_r};
      pend_after = 3'b000;
    end
  end

  // Next state and control
  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    prog_nxt       = prog_r;
    off_nxt        = off_r;
    pend_nxt       = pend_r;
    voice_vld_nxt  = voice_vld_r;
    prog_vld_nxt   = prog_vld_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (tnmve_pkg::kind_t'(in_tuser))
            tnmve_pkg::KIND_NOTE, tnmve_pkg::KIND_STOP: state_nxt = S_LOOKUP;
            tnmve_pkg::KIND_RESET_PROG: prog_vld_nxt = '0;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOOKUP: begin
        ch_nxt   = ch_sel;
        prog_nxt = map_rdata.prog_num[6:0];
        off_nxt  = voice_rdata;
        pend_nxt = {need_on, need_off, need_prog};
        if (need_prog) begin
          prog_vld_nxt[ch_sel] = 1'b1;
        end
        if (need_on) begin
          voice_vld_nxt[tc_idx] = 1'b1;
        end else if (need_off) begin
          voice_vld_nxt[tc_idx] = 1'b0;
        end
        state_nxt = (need_prog || need_off || need_on) ? S_SEND : S_IDLE;
      end
      S_SEND: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = msg;
          out_tlast_nxt  = (pend_after == 3'b000);
          pend_nxt       = pend_after;
          if (pend_after == 3'b000) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, configuration and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      use_map_r     <= 1'b0;
      note_offset_r <= 8'd0;
      pend_r        <= 3'b000;
      voice_vld_r   <= '0;
      prog_vld_r    <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      voice_vld_r  <= voice_vld_nxt;
      prog_vld_r   <= prog_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tnmve_pkg::CFG_USE_MAP:     use_map_r     <= cfg_data[0];
          tnmve_pkg::CFG_NOTE_OFFSET: note_offset_r <= cfg_data;
          default:                    use_map_r     <= use_map_r;
        endcase
      end
    end
    // Capture the item
    if (in_acc) begin
      kind_r <= tnmve_pkg::kind_t'(in_tuser);
      tc_r   <= in_tc;
      idx_r  <= in_idx;
      mn_r   <= mn_in;
      vel_r  <= vel_in;
    end
    // Update the program cache entry
    if ((state_r == S_LOOKUP) && need_prog) begin
      prog_cache_r[ch_sel] <= map_rdata.prog_num[6:0];
    end
    ch_r        <= ch_nxt;
    prog_r      <= prog_nxt;
    off_r       <= off_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

// File: dv/tracker_note_to_midi_voice_engine_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of tracker_note_to_midi_voice_engine_top: a directed
// table, then random phases under several map/offset settings, checked item by
// item against a behavioral voice engine. Depends on tnmve_pkg and the top RTL.

module tracker_note_to_midi_voice_engine_top_tb;
  import tnmve_pkg::*;

  localparam int IDLE_PCT = 28;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 21;
  localparam int PHASES = 6;
  localparam int VOL_FULL = 64;
  localparam logic [7:0] PROG_EMPTY = 8'hFF;

  // One input item, field by field
  typedef struct packed {
    kind_t      kind;
    logic [5:0] tc;
    logic [7:0] note;
    logic [8:0] instr;
    logic [7:0] vol;
    logic [7:0] map_idx;
    logic [4:0] map_ch;
    logic [7:0] map_prog;
  } note_item_t;

  // One MIDI message on the result side
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [1:0] byte_count;
    logic       last;
  } midi_msg_t;

  // Directed row: either a register setting or an item with optional fixed results
  typedef struct packed {
    logic                  set_cfg;
    logic                  cfg_map;
    logic [7:0]            cfg_off;
    note_item_t            item;
    logic                  fixed;
    logic [1:0]            n_fixed;
    midi_msg_t [2:0]       fixed_msgs;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [23:0] out_tdata;
  wire         out_tlast;
  wire         cfg_ready;

  // Behavioral copy of the engine state and registers
  logic       m_use_map;
  logic [7:0] m_offset;
  logic       voice_on   [TRACKER_CHANNELS];
  logic [3:0] voice_ch   [TRACKER_CHANNELS];
  logic [6:0] voice_note [TRACKER_CHANNELS];
  logic [7:0] prog_cache [MIDI_CHANNELS];
  logic [4:0] map_ch_tab   [INSTRUMENT_COUNT];
  logic [7:0] map_prog_tab [INSTRUMENT_COUNT];
  logic       map_written  [INSTRUMENT_COUNT];
  int         loaded_idx[$];

  midi_msg_t  fresh_msgs[$];
  midi_msg_t  pending_msgs[$];
  dir_row_t   dir_table[$];
  int         err_cnt = 0;
  logic       steady = 1'b0;

  tracker_note_to_midi_voice_engine_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the engine hangs
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic idle_now();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  task automatic push_msg(input logic [7:0] status, input logic [6:0] d1,
                          input logic [6:0] d2, input logic [1:0] cnt);
    midi_msg_t m;
    m.status = status;
    m.data_one = d1;
    m.data_two = d2;
    m.byte_count = cnt;
    m.last = 1'b0;
    fresh_msgs.push_back(m);
  endtask

  // Send the note-off of a sounding voice and free it
  task automatic release_voice(input logic [5:0] tc);
    if (voice_on[tc]) begin
      push_msg({ST_NOTE_OFF, voice_ch[tc]}, voice_note[tc], 7'd0, LEN_NOTE);
      voice_on[tc] = 1'b0;
    end
  endtask

  // Work out the messages one accepted item causes and advance the engine state
  task automatic render_midi(input note_item_t it);
    int idx;
    int mn;
    int off;
    int vel;
    logic [3:0] ch;
    logic [7:0] prog;
    fresh_msgs.delete();
    case (it.kind)
      KIND_NOTE: begin
        idx = (it.instr > 0) ? int'(it.instr) - 1 : 0;
        if (m_use_map) begin
          if (idx >= INSTRUMENT_COUNT) return;
          if (map_ch_tab[idx] >= MIDI_CHANNELS) return;
          ch = map_ch_tab[idx][3:0];
          prog = map_prog_tab[idx];
          if (prog < PROG_LIMIT && prog_cache[ch] != prog) begin
            push_msg({ST_PROGRAM, ch}, prog[6:0], 7'd0, LEN_PROGRAM);
            prog_cache[ch] = prog;
          end
        end else begin
          ch = 4'(idx % MIDI_CHANNELS);
        end
        // clamp, offset, clamp again
        mn = (it.note > NOTE_MAX) ? NOTE_MAX : int'(it.note);
        off = $signed(m_offset);
        mn = mn + off;
        if (mn < 0) mn = 0;
        if (mn > NOTE_MAX) mn = NOTE_MAX;
        vel = int'(it.vol) * VEL_SCALE / VOL_FULL;
        if (vel > VEL_SCALE) vel = VEL_SCALE;
        release_voice(it.tc);
        if (vel > 0) begin
          push_msg({ST_NOTE_ON, ch}, 7'(mn), 7'(vel), LEN_NOTE);
          voice_on[it.tc] = 1'b1;
          voice_ch[it.tc] = ch;
          voice_note[it.tc] = 7'(mn);
        end
      end
      KIND_STOP: release_voice(it.tc);
      KIND_RESET_PROG: begin
        foreach (prog_cache[i]) prog_cache[i] = PROG_EMPTY;
      end
      default: begin
        map_ch_tab[it.map_idx] = it.map_ch;
        map_prog_tab[it.map_idx] = it.map_prog;
        if (!map_written[it.map_idx]) loaded_idx.push_back(int'(it.map_idx));
        map_written[it.map_idx] = 1'b1;
      end
    endcase
    if (fresh_msgs.size() > 0) fresh_msgs[fresh_msgs.size() - 1].last = 1'b1;
  endtask

  // Drive one item until it is taken, then predict its messages
  task automatic send_item(input note_item_t it);
    while (idle_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.kind;
    in_tdata <= {4'd0, it.map_prog, it.map_ch, it.map_idx, it.vol, it.instr, it.note, it.tc};
    do @(posedge clk); while (!in_tready);
    render_midi(it);
  endtask

  // Hold off input until every message is out and the pipeline has emptied
  task automatic drain_engine();
    in_tvalid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_USE_MAP) m_use_map = val[0];
    else m_offset = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic use_map, input logic [7:0] off);
    drain_engine();
    write_reg(CFG_USE_MAP, {7'd0, use_map});
    write_reg(CFG_NOTE_OFFSET, off);
  endtask

  task automatic add_item(input kind_t k, input int tc, input int note, input int instr,
                          input int vol, input int midx, input int mch, input int mprog);
    dir_row_t row;
    row = '0;
    row.item.kind = k;
    row.item.tc = 6'(tc);
    row.item.note = 8'(note);
    row.item.instr = 9'(instr);
    row.item.vol = 8'(vol);
    row.item.map_idx = 8'(midx);
    row.item.map_ch = 5'(mch);
    row.item.map_prog = 8'(mprog);
    dir_table.push_back(row);
  endtask

  task automatic add_cfg(input logic use_map, input logic [7:0] off);
    dir_row_t row;
    row = '0;
    row.set_cfg = 1'b1;
    row.cfg_map = use_map;
    row.cfg_off = off;
    dir_table.push_back(row);
  endtask

  // Attach fixed results to the latest row
  task automatic expect_none();
    dir_row_t row;
    row = dir_table.pop_back();
    row.fixed = 1'b1;
    dir_table.push_back(row);
  endtask

  task automatic expect_msg(input logic [7:0] status, input int d1, input int d2,
                            input logic [1:0] cnt);
    dir_row_t row;
    row = dir_table.pop_back();
    row.fixed = 1'b1;
    row.fixed_msgs[row.n_fixed].status = status;
    row.fixed_msgs[row.n_fixed].data_one = 7'(d1);
    row.fixed_msgs[row.n_fixed].data_two = 7'(d2);
    row.fixed_msgs[row.n_fixed].byte_count = cnt;
    row.fixed_msgs[row.n_fixed].last = 1'b0;
    row.n_fixed = row.n_fixed + 1;
    dir_table.push_back(row);
  endtask

  // Mostly playable items on a few voices; map loads reuse a small index range
  function automatic note_item_t random_item();
    note_item_t it;
    int r;
    int idx;
    it.tc = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
    it.note = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                          : 8'($urandom_range(0, 127));
    r = $urandom_range(0, 7);
    if (r == 0) it.vol = 8'd0;
    else if (r == 1) it.vol = 8'($urandom_range(64, 255));
    else it.vol = 8'($urandom_range(1, 64));
    it.map_idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    it.map_ch = ($urandom_range(0, 5) == 0) ? 5'd16 : 5'($urandom_range(0, 15));
    it.map_prog = ($urandom_range(0, 4) == 0) ? 8'd128 : 8'($urandom_range(0, 127));
    if (m_use_map) begin
      // only instruments whose map entry is loaded
      idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
      it.instr = (idx == 0 && $urandom_range(0, 1)) ? 9'd0 : 9'(idx + 1);
    end else begin
      it.instr = 9'($urandom_range(0, 256));
    end
    r = $urandom_range(0, 99);
    if (r < 62) it.kind = KIND_NOTE;
    else if (r < 77) it.kind = KIND_STOP;
    else if (r < 82) it.kind = KIND_RESET_PROG;
    else it.kind = KIND_LOAD_MAP;
    return it;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Result side: random stalls, compare each taken item with the oldest prediction
  always @(posedge clk) begin : rx_side
    midi_msg_t want;
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_msgs.size() == 0) begin
        $error("unexpected result: status %0h data_one %0d", out_tdata[7:0], out_tdata[14:8]);
        err_cnt++;
      end else begin
        want = pending_msgs.pop_front();
        check_field("status_byte", want.status, out_tdata[7:0]);
        check_field("data_one", want.data_one, out_tdata[14:8]);
        check_field("data_two", want.data_two, out_tdata[21:15]);
        check_field("byte_count", want.byte_count, out_tdata[23:22]);
        check_field("last_of_run", want.last, out_tlast);
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    note_item_t it;
    midi_msg_t m;
    logic [7:0] off;

    m_use_map = 1'b0;
    m_offset = 8'd0;
    foreach (voice_on[i]) voice_on[i] = 1'b0;
    foreach (prog_cache[i]) prog_cache[i] = PROG_EMPTY;
    foreach (map_written[i]) map_written[i] = 1'b0;

    // Directed table, index mode first
    add_cfg(1'b0, 8'h00);
    add_item(KIND_NOTE, 0, 60, 1, 64, 0, 0, 0);
    expect_msg({ST_NOTE_ON, 4'd0}, 60, 127, LEN_NOTE);
    add_item(KIND_NOTE, 0, 255, 256, 255, 0, 0, 0);
    expect_msg({ST_NOTE_OFF, 4'd0}, 60, 0, LEN_NOTE);
    expect_msg({ST_NOTE_ON, 4'd15}, 127, 127, LEN_NOTE);
    add_item(KIND_NOTE, 63, 0, 0, 1, 0, 0, 0);
    expect_msg({ST_NOTE_ON, 4'd0}, 0, 1, LEN_NOTE);
    add_item(KIND_STOP, 63, 0, 0, 0, 0, 0, 0);
    expect_msg({ST_NOTE_OFF, 4'd0}, 0, 0, LEN_NOTE);
    add_item(KIND_STOP, 63, 0, 0, 0, 0, 0, 0);
    expect_none();
    // zero velocity only silences
    add_item(KIND_NOTE, 0, 10, 5, 0, 0, 0, 0);
    expect_msg({ST_NOTE_OFF, 4'd15}, 127, 0, LEN_NOTE);
    add_item(KIND_NOTE, 1, 200, 17, 32, 0, 0, 0);
    add_item(KIND_NOTE, 1, 64, 511, 40, 0, 0, 0);
    // map entries: plain, disabled, no program, top index, shared program
    add_item(KIND_LOAD_MAP, 0, 0, 0, 0, 0, 3, 5);
    expect_none();
    add_item(KIND_LOAD_MAP, 0, 0, 0, 0, 1, 16, 0);
    expect_none();
    add_item(KIND_LOAD_MAP, 0, 0, 0, 0, 2, 15, 128);
    expect_none();
    add_item(KIND_LOAD_MAP, 0, 0, 0, 0, 255, 0, 127);
    expect_none();
    add_item(KIND_LOAD_MAP, 0, 0, 0, 0, 4, 3, 5);
    expect_none();
    add_item(KIND_RESET_PROG, 0, 0, 0, 0, 0, 0, 0);
    expect_none();
    // map mode
    add_cfg(1'b1, 8'h00);
    add_item(KIND_NOTE, 2, 60, 1, 64, 0, 0, 0);
    expect_msg({ST_PROGRAM, 4'd3}, 5, 0, LEN_PROGRAM);
    expect_msg({ST_NOTE_ON, 4'd3}, 60, 127, LEN_NOTE);
    add_item(KIND_NOTE, 2, 61, 5, 48, 0, 0, 0);
    add_item(KIND_NOTE, 3, 40, 2, 64, 0, 0, 0);
    expect_none();
    add_item(KIND_NOTE, 3, 127, 3, 64, 0, 0, 0);
    add_item(KIND_NOTE, 4, 50, 256, 20, 0, 0, 0);
    // instrument beyond the map counts as disabled
    add_item(KIND_NOTE, 4, 50, 511, 20, 0, 0, 0);
    expect_none();
    add_item(KIND_RESET_PROG, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_NOTE, 2, 70, 1, 100, 0, 0, 0);
    // offset extremes, clamped both ways
    add_cfg(1'b1, 8'h7F);
    add_item(KIND_NOTE, 5, 0, 1, 64, 0, 0, 0);
    add_item(KIND_NOTE, 6, 255, 5, 64, 0, 0, 0);
    add_cfg(1'b0, 8'h81);
    add_item(KIND_NOTE, 5, 100, 3, 64, 0, 0, 0);
    add_item(KIND_NOTE, 7, 127, 9, 64, 0, 0, 0);
    add_item(KIND_STOP, 1, 0, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_table[i]) begin
      row = dir_table[i];
      if (row.set_cfg) begin
        set_config(row.cfg_map, row.cfg_off);
      end else begin
        send_item(row.item);
        if (row.fixed) begin
          for (int k = 0; k < row.n_fixed; k++) begin
            m = row.fixed_msgs[k];
            m.last = (k == row.n_fixed - 1);
            pending_msgs.push_back(m);
          end
        end else begin
          foreach (fresh_msgs[k]) pending_msgs.push_back(fresh_msgs[k]);
        end
      end
    end

    // Random phases over several register settings
    for (int p = 0; p < PHASES; p++) begin
      off = 8'($urandom_range(0, 254) - 127);
      case (p)
        0: set_config(1'b0, 8'h00);
        1: set_config(1'b1, off);
        2: set_config(1'b0, 8'h7F);
        3: set_config(1'b1, 8'h81);
        4: set_config(1'b0, off);
        default: set_config(1'b1, 8'h00);
      endcase
      // one phase runs with both sides never idling
      steady = (p == 2);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        it = random_item();
        send_item(it);
        foreach (fresh_msgs[k]) pending_msgs.push_back(fresh_msgs[k]);
      end
    end
    steady = 1'b0;
    drain_engine();

    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
sv/tnmve_pkg.sv
sv/tnmve_ram.sv
sv/tracker_note_to_midi_voice_engine_top.sv
dv/tracker_note_to_midi_voice_engine_top_tb.sv
